// ----- hdl/tmat_pkg.sv -----
// ----------------------------------------------------------------------------
// tmat_pkg
// Shared types and codes for the tunnel match-action table.
// ----------------------------------------------------------------------------
package tmat_pkg;

  localparam int TUNNEL_SLOTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int UID_W            = 16;

  localparam logic [1:0] FN_CLASSIFY   = 2'd0;
  localparam logic [1:0] FN_ACTIVATE   = 2'd1;
  localparam logic [1:0] FN_DEACTIVATE = 2'd2;
  localparam logic [1:0] FN_UNUSED     = 2'd3;

  localparam logic [7:0] BG_CLASS = 8'd2;

  localparam logic [3:0] ACT_IGNORED     = 4'd0;
  localparam logic [3:0] ACT_NOMATCH     = 4'd1;
  localparam logic [3:0] ACT_IN          = 4'd2;
  localparam logic [3:0] ACT_OUT         = 4'd3;
  localparam logic [3:0] ACT_FROM_OUT_MG = 4'd4;
  localparam logic [3:0] ACT_FROM_OUT_NM = 4'd5;
  localparam logic [3:0] ACT_FROM_IN_MG  = 4'd6;
  localparam logic [3:0] ACT_FROM_IN_P1  = 4'd7;
  localparam logic [3:0] ACT_FROM_IN_P2  = 4'd8;
  localparam logic [3:0] ACT_TO_P1       = 4'd9;
  localparam logic [3:0] ACT_TO_P2_NM    = 4'd10;
  localparam logic [3:0] ACT_TO_P2_MG    = 4'd11;
  localparam logic [3:0] ACT_FROM_NONE   = 4'd12;
  localparam logic [3:0] ACT_ACTIVATED   = 4'd13;
  localparam logic [3:0] ACT_DEACTIVATED = 4'd14;
  localparam logic [3:0] ACT_FULL        = 4'd15;

  localparam logic [1:0] PRIO_LEAVE = 2'd0;
  localparam logic [1:0] PRIO_SET   = 2'd1;
  localparam logic [1:0] PRIO_CLEAR = 2'd2;

  typedef struct packed {
    logic [3:0]       action;
    logic [UID_W-1:0] uid;
    logic [15:0]      new_src;
    logic [15:0]      new_dst;
    logic [15:0]      push_addr;
    logic [1:0]       high_prio;
    logic             skip;
    logic             consumed;
  } result_t;

endpackage

// ----- hdl/tmat_store.sv -----
// ----------------------------------------------------------------------------
// tmat_store
// Tunnel entry memory: one write port, one registered read port, plus
// per-slot valid bits cleared at reset.
// ----------------------------------------------------------------------------
module tmat_store #(
  parameter int TUNNEL_SLOTS = tmat_pkg::TUNNEL_SLOTS_DEF,
  parameter int ADDR_BITS    = tmat_pkg::ADDR_BITS_DEF,
  localparam int IW = (TUNNEL_SLOTS > 1) ? $clog2(TUNNEL_SLOTS) : 1,
  localparam int EW = 4 * ADDR_BITS + tmat_pkg::UID_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IW-1:0]           rd_idx,
  output logic [EW-1:0]           rd_data,
  input  logic                    wr_en,
  input  logic [IW-1:0]           wr_idx,
  input  logic [EW-1:0]           wr_data,
  input  logic                    set_en,
  input  logic                    clr_en,
  input  logic [IW-1:0]           vld_idx,
  output logic [TUNNEL_SLOTS-1:0] valid
);

  logic [EW-1:0]           mem [TUNNEL_SLOTS];
  logic [EW-1:0]           rd_data_r;
  logic [TUNNEL_SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (set_en) begin
      valid_r[vld_idx] <= 1'b1;
    end else if (clr_en) begin
      valid_r[vld_idx] <= 1'b0;
    end
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule

// ----- hdl/tmat_match.sv -----
// ----------------------------------------------------------------------------
// tmat_match
// Role match and action decode for one table entry against one packet.
// ----------------------------------------------------------------------------
module tmat_match #(
  parameter int ADDR_BITS = tmat_pkg::ADDR_BITS_DEF
) (
  input  logic [ADDR_BITS-1:0]       e_in,
  input  logic [ADDR_BITS-1:0]       e_out,
  input  logic [ADDR_BITS-1:0]       e_from,
  input  logic [ADDR_BITS-1:0]       e_to,
  input  logic [tmat_pkg::UID_W-1:0] e_uid,
  input  logic [15:0]                node,
  input  logic [15:0]                src,
  input  logic [15:0]                dst,
  input  logic                       normal,
  input  logic                       skip,
  output logic                       hit,
  output tmat_pkg::result_t          res
);

  logic [15:0] a_in, a_out, a_from, a_to;

  always_comb begin
    a_in   = 16'(e_in);
    a_out  = 16'(e_out);
    a_from = 16'(e_from);
    a_to   = 16'(e_to);
    hit = 1'b0;
    res = '0;
    res.uid     = e_uid;
    res.new_src = src;
    res.new_dst = dst;
    res.skip    = skip;
    if (node == a_in) begin
      if (dst == a_from || src == a_to) begin
        hit = 1'b1;
        res.action    = tmat_pkg::ACT_IN;
        res.push_addr = a_out;
        res.high_prio = tmat_pkg::PRIO_SET;
      end
    end else if (node == a_out) begin
      if (src == a_to || dst == a_to) begin
        hit = 1'b1;
        res.action    = tmat_pkg::ACT_OUT;
        res.high_prio = tmat_pkg::PRIO_CLEAR;
      end
    end else if (node == a_from) begin
      if (dst == a_from || src == a_from) begin
        hit = 1'b1;
        if (dst == node) begin
          if (!normal) begin
            res.action    = tmat_pkg::ACT_FROM_IN_MG;
            res.new_dst   = a_to;
            res.high_prio = tmat_pkg::PRIO_SET;
          end else if (!skip) begin
            res.action = tmat_pkg::ACT_FROM_IN_P1;
            res.skip   = 1'b1;
          end else begin
            res.action   = tmat_pkg::ACT_FROM_IN_P2;
            res.consumed = 1'b1;
          end
        end else if (src == node) begin
          if (!normal) begin
            res.action   = tmat_pkg::ACT_FROM_OUT_MG;
            res.new_src  = a_to;
            res.consumed = 1'b1;
          end else begin
            res.action = tmat_pkg::ACT_FROM_OUT_NM;
          end
        end else begin
          res.action = tmat_pkg::ACT_FROM_NONE;
        end
      end
    end else if (node == a_to) begin
      if (dst == a_to) begin
        hit = 1'b1;
        if (!skip) begin
          res.action = tmat_pkg::ACT_TO_P1;
          res.skip   = 1'b1;
        end else if (normal) begin
          res.action   = tmat_pkg::ACT_TO_P2_NM;
          res.skip     = 1'b0;
          res.new_dst  = a_from;
          res.consumed = 1'b1;
        end else begin
          res.action = tmat_pkg::ACT_TO_P2_MG;
          res.skip   = 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/tunnel_match_action_table.sv -----
// ----------------------------------------------------------------------------
// tunnel_match_action_table
// Migration tunnel table with packet classification.
// ----------------------------------------------------------------------------
// Entries live in a synchronous memory read one slot per cycle.
// A deactivate request, or a classify request not in the background
// class, scans slots in order and stops at the first hit. Activate,
// background and unused requests need no scan; activate takes the free
// slot from the valid bits. The result sits in an output register; one
// request is worked at a time and the next is taken the cycle after the
// previous result is handed off.
module tunnel_match_action_table #(
  parameter int TUNNEL_SLOTS = tmat_pkg::TUNNEL_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [15:0]          in_node_addr,
  input  logic [15:0]          in_pkt_src,
  input  logic [15:0]          in_pkt_dst,
  input  logic [7:0]           in_traffic_class,
  input  logic [1:0]           in_mig_state,
  input  logic                 in_skip_flag_in,
  input  logic [15:0]          in_in_addr,
  input  logic [15:0]          in_out_addr,
  input  logic [15:0]          in_from_addr,
  input  logic [15:0]          in_to_addr,
  input  logic [15:0]          in_tunnel_uid,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_action,
  output logic [15:0]          out_uid_out,
  output logic [15:0]          out_new_src,
  output logic [15:0]          out_new_dst,
  output logic [15:0]          out_push_addr,
  output logic [1:0]           out_high_prio,
  output logic                 out_skip_flag_out,
  output logic                 out_consumed
);

  localparam int ADDR_BITS = tmat_pkg::ADDR_BITS_DEF;
  localparam int IW  = (TUNNEL_SLOTS > 1) ? $clog2(TUNNEL_SLOTS) : 1;
  localparam int CW  = $clog2(TUNNEL_SLOTS + 1);
  localparam int UW  = tmat_pkg::UID_W;
  localparam int EW  = 4 * ADDR_BITS + UW;
  localparam logic [CW-1:0] LAST = CW'(TUNNEL_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;   // slot being addressed
  logic [CW-1:0] ck_cnt_r, ck_cnt_nxt;   // slot whose data is on the port
  logic          ck_vld_r, ck_vld_nxt;
  logic [UW-1:0] next_uid_r, next_uid_nxt;

  logic [1:0]  func_r;
  logic [15:0] node_r, src_r, dst_r, uid_q_r;
  logic        normal_r, skip_r;

  tmat_pkg::result_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [EW-1:0]           rd_data;
  logic [TUNNEL_SLOTS-1:0] valid;
  logic                    wr_en, set_en, clr_en;
  logic [IW-1:0]           vld_idx, free_idx;
  logic                    free_found;
  logic                    take;
  logic                    hit;
  tmat_pkg::result_t       mres;
  logic [ADDR_BITS-1:0]    e_in, e_out, e_from, e_to;
  logic [UW-1:0]           e_uid;
  logic                    slot_ok;

  assign take     = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;

  assign {e_in, e_out, e_from, e_to, e_uid} = rd_data;

  // lowest free slot from the valid bits
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TUNNEL_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  tmat_store #(.TUNNEL_SLOTS(TUNNEL_SLOTS), .ADDR_BITS(ADDR_BITS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_cnt_r[IW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (free_idx),
    .wr_data ({in_in_addr[ADDR_BITS-1:0] & {ADDR_BITS{1'b1}},
               in_out_addr[ADDR_BITS-1:0], in_from_addr[ADDR_BITS-1:0],
               in_to_addr[ADDR_BITS-1:0], next_uid_r}),
    .set_en  (set_en),
    .clr_en  (clr_en),
    .vld_idx (vld_idx),
    .valid   (valid)
  );

  tmat_match #(.ADDR_BITS(ADDR_BITS)) u_match (
    .e_in   (e_in),
    .e_out  (e_out),
    .e_from (e_from),
    .e_to   (e_to),
    .e_uid  (e_uid),
    .node   (node_r),
    .src    (src_r),
    .dst    (dst_r),
    .normal (normal_r),
    .skip   (skip_r),
    .hit    (hit),
    .res    (mres)
  );

  assign slot_ok = ck_vld_r && valid[ck_cnt_r[IW-1:0]];

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    ck_cnt_nxt    = ck_cnt_r;
    ck_vld_nxt    = 1'b0;
    next_uid_nxt  = next_uid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    set_en        = 1'b0;
    clr_en        = 1'b0;
    vld_idx       = free_idx;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          res_nxt = '0;
          unique case (in_func)
            tmat_pkg::FN_CLASSIFY: begin
              res_nxt.new_src = in_pkt_src;
              res_nxt.new_dst = in_pkt_dst;
              res_nxt.skip    = in_skip_flag_in;
              if (in_traffic_class == tmat_pkg::BG_CLASS) begin
                res_nxt.action = tmat_pkg::ACT_IGNORED;
                state_nxt      = ST_OUT;
              end else begin
                rd_cnt_nxt = '0;
                state_nxt  = ST_SCAN;
              end
            end
            tmat_pkg::FN_ACTIVATE: begin
              if (free_found) begin
                wr_en          = 1'b1;
                set_en         = 1'b1;
                res_nxt.action = tmat_pkg::ACT_ACTIVATED;
                res_nxt.uid    = next_uid_r;
                next_uid_nxt   = next_uid_r + 1'b1;
              end else begin
                res_nxt.action = tmat_pkg::ACT_FULL;
              end
              state_nxt = ST_OUT;
            end
            tmat_pkg::FN_DEACTIVATE: begin
              res_nxt.uid = in_tunnel_uid;
              rd_cnt_nxt  = '0;
              state_nxt   = ST_SCAN;
            end
            default: begin
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue next read while checking the slot returned last cycle
        if (rd_cnt_r <= LAST) begin
          ck_cnt_nxt = rd_cnt_r;
          ck_vld_nxt = 1'b1;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (func_r == tmat_pkg::FN_CLASSIFY) begin
          if (slot_ok && hit) begin
            res_nxt   = mres;
            state_nxt = ST_OUT;
          end else if (ck_vld_r && ck_cnt_r == LAST) begin
            res_nxt.action    = tmat_pkg::ACT_NOMATCH;
            res_nxt.high_prio = tmat_pkg::PRIO_CLEAR;
            state_nxt         = ST_OUT;
          end
        end else begin
          if (slot_ok && e_uid == uid_q_r) begin
            clr_en         = 1'b1;
            vld_idx        = ck_cnt_r[IW-1:0];
            res_nxt.action = tmat_pkg::ACT_DEACTIVATED;
            state_nxt      = ST_OUT;
          end else if (ck_vld_r && ck_cnt_r == LAST) begin
            res_nxt.action = tmat_pkg::ACT_NOMATCH;
            state_nxt      = ST_OUT;
          end
        end
        if (state_nxt == ST_OUT) begin
          ck_vld_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      ck_cnt_r    <= '0;
      ck_vld_r    <= 1'b0;
      next_uid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      ck_cnt_r    <= ck_cnt_nxt;
      ck_vld_r    <= ck_vld_nxt;
      next_uid_r  <= next_uid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (take) begin
      func_r   <= in_func;
      node_r   <= in_node_addr;
      src_r    <= in_pkt_src;
      dst_r    <= in_pkt_dst;
      normal_r <= (in_mig_state == 2'd0);
      skip_r   <= in_skip_flag_in;
      uid_q_r  <= in_tunnel_uid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = res_r.action;
  assign out_uid_out       = res_r.uid;
  assign out_new_src       = res_r.new_src;
  assign out_new_dst       = res_r.new_dst;
  assign out_push_addr     = res_r.push_addr;
  assign out_high_prio     = res_r.high_prio;
  assign out_skip_flag_out = res_r.skip;
  assign out_consumed      = res_r.consumed;

endmodule

// ----- hdl/tmat_checker.sv -----
// ----------------------------------------------------------------------------
// tmat_checker
// Port-level checks for the tunnel match-action table.
// ----------------------------------------------------------------------------
module tmat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_action,
  input logic [1:0]  out_high_prio,
  input logic [15:0] out_push_addr
);

  // one request in flight: no request taken while a result waits
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action))
    else $error("stalled result changed");

  // no result can appear the cycle after a request was taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  a_nomatch_prio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == tmat_pkg::ACT_NOMATCH |-> out_push_addr == 16'd0)
    else $error("push address on non-tunnel action");

  a_act_prio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == tmat_pkg::ACT_ACTIVATED ||
                  out_action == tmat_pkg::ACT_DEACTIVATED ||
                  out_action == tmat_pkg::ACT_FULL)
      |-> out_high_prio == tmat_pkg::PRIO_LEAVE)
    else $error("priority set on table update");

endmodule

bind tunnel_match_action_table tmat_checker u_tmat_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_action    (out_action),
  .out_high_prio (out_high_prio),
  .out_push_addr (out_push_addr)
);

// ----- tb/tb_tunnel_match_action_table.sv -----
// ----------------------------------------------------------------------------
// tb_tunnel_match_action_table
// Drives activate, deactivate, classify and unused requests with random
// handshake gaps and checks every result against a behavioral table model.
// ----------------------------------------------------------------------------
module tb_tunnel_match_action_table;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] node, src, dst;
    logic [7:0]  tclass;
    logic [1:0]  mig;
    logic        skip;
    logic [15:0] a_in, a_out, a_from, a_to, uid;
  } request_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  in_func, in_mig_state;
  logic [15:0] in_node_addr, in_pkt_src, in_pkt_dst;
  logic [7:0]  in_traffic_class;
  logic        in_skip_flag_in;
  logic [15:0] in_in_addr, in_out_addr, in_from_addr, in_to_addr, in_tunnel_uid;
  logic [3:0]  out_action;
  logic [15:0] out_uid_out, out_new_src, out_new_dst, out_push_addr;
  logic [1:0]  out_high_prio;
  logic        out_skip_flag_out, out_consumed;

  tunnel_match_action_table dut (.*);

  // model of the tunnel table
  logic        tun_valid [SLOTS];
  logic [15:0] tun_in [SLOTS], tun_out [SLOTS], tun_from [SLOTS], tun_to [SLOTS];
  logic [15:0] tun_uid [SLOTS];
  logic [15:0] uid_counter;

  tmat_pkg::result_t expected_results[$];
  int  errors = 0;
  int  idle_pct = 11;
  int  quiet_cycles = 0;
  bit  done = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic tmat_pkg::result_t predict_table(request_t r);
    tmat_pkg::result_t o;
    logic normal;
    int role;
    o = '0;
    case (r.func)
      tmat_pkg::FN_CLASSIFY: begin
        normal = (r.mig == 2'd0);
        o.new_src = r.src;
        o.new_dst = r.dst;
        o.skip = r.skip;
        if (r.tclass == tmat_pkg::BG_CLASS) begin
          o.action = tmat_pkg::ACT_IGNORED;
          return o;
        end
        for (int s = 0; s < SLOTS; s++) begin
          if (!tun_valid[s]) continue;
          role = 0;
          if (r.node == tun_in[s]) begin
            if (r.dst == tun_from[s] || r.src == tun_to[s]) role = 1;
          end else if (r.node == tun_out[s]) begin
            if (r.src == tun_to[s] || r.dst == tun_to[s]) role = 2;
          end else if (r.node == tun_from[s]) begin
            if (r.dst == tun_from[s] || r.src == tun_from[s]) role = 3;
          end else if (r.node == tun_to[s]) begin
            if (r.dst == tun_to[s]) role = 4;
          end
          if (role == 0) continue;
          o.uid = tun_uid[s];
          if (role == 1) begin
            o.action = tmat_pkg::ACT_IN; o.push_addr = tun_out[s];
            o.high_prio = tmat_pkg::PRIO_SET;
          end else if (role == 2) begin
            o.action = tmat_pkg::ACT_OUT; o.high_prio = tmat_pkg::PRIO_CLEAR;
          end else if (role == 3) begin
            if (r.dst == r.node) begin
              if (!normal) begin
                o.action = tmat_pkg::ACT_FROM_IN_MG; o.new_dst = tun_to[s];
                o.high_prio = tmat_pkg::PRIO_SET;
              end else if (!r.skip) begin
                o.action = tmat_pkg::ACT_FROM_IN_P1; o.skip = 1;
              end else begin
                o.action = tmat_pkg::ACT_FROM_IN_P2; o.consumed = 1;
              end
            end else if (r.src == r.node) begin
              if (!normal) begin
                o.action = tmat_pkg::ACT_FROM_OUT_MG; o.new_src = tun_to[s];
                o.consumed = 1;
              end else o.action = tmat_pkg::ACT_FROM_OUT_NM;
            end else o.action = tmat_pkg::ACT_FROM_NONE;
          end else begin
            if (!r.skip) begin
              o.action = tmat_pkg::ACT_TO_P1; o.skip = 1;
            end else if (normal) begin
              o.action = tmat_pkg::ACT_TO_P2_NM; o.skip = 0;
              o.new_dst = tun_from[s]; o.consumed = 1;
            end else begin
              o.action = tmat_pkg::ACT_TO_P2_MG; o.skip = 0;
            end
          end
          return o;
        end
        o.action = tmat_pkg::ACT_NOMATCH;
        o.high_prio = tmat_pkg::PRIO_CLEAR;
      end
      tmat_pkg::FN_ACTIVATE: begin
        o.action = tmat_pkg::ACT_FULL;
        for (int s = 0; s < SLOTS; s++) begin
          if (!tun_valid[s]) begin
            tun_valid[s] = 1;
            tun_in[s] = r.a_in; tun_out[s] = r.a_out;
            tun_from[s] = r.a_from; tun_to[s] = r.a_to;
            tun_uid[s] = uid_counter;
            o.action = tmat_pkg::ACT_ACTIVATED;
            o.uid = uid_counter;
            uid_counter = uid_counter + 16'd1;
            break;
          end
        end
      end
      tmat_pkg::FN_DEACTIVATE: begin
        o.uid = r.uid;
        o.action = tmat_pkg::ACT_NOMATCH;
        for (int s = 0; s < SLOTS; s++) begin
          if (tun_valid[s] && tun_uid[s] == r.uid) begin
            tun_valid[s] = 0;
            o.action = tmat_pkg::ACT_DEACTIVATED;
            break;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_request(request_t r);
    tmat_pkg::result_t e;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_func <= r.func; in_node_addr <= r.node; in_pkt_src <= r.src;
    in_pkt_dst <= r.dst; in_traffic_class <= r.tclass; in_mig_state <= r.mig;
    in_skip_flag_in <= r.skip; in_in_addr <= r.a_in; in_out_addr <= r.a_out;
    in_from_addr <= r.a_from; in_to_addr <= r.a_to; in_tunnel_uid <= r.uid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = predict_table(r);
    expected_results.insert(expected_results.size(), e);
  endtask

  function automatic request_t rand_request();
    request_t r;
    r.func = 2'($urandom_range(3)); r.node = 16'($urandom);
    r.src = 16'($urandom); r.dst = 16'($urandom);
    r.tclass = 8'($urandom); r.mig = 2'($urandom_range(3));
    r.skip = 1'($urandom_range(1));
    r.a_in = 16'($urandom); r.a_out = 16'($urandom);
    r.a_from = 16'($urandom); r.a_to = 16'($urandom);
    r.uid = 16'($urandom);
    return r;
  endfunction

  // pick an address from a small pool so tunnels and packets collide often
  function automatic logic [15:0] pool_addr();
    logic [15:0] pool [8] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000,
                              16'h1234, 16'h5555, 16'haaaa, 16'h00ff};
    return pool[3'($urandom_range(7))];
  endfunction

  // packet aimed at a random tunnel slot from a random role
  function automatic request_t tunnel_packet();
    request_t r;
    logic [3:0] s;
    r = rand_request();
    r.func = tmat_pkg::FN_CLASSIFY;
    if ($urandom_range(9) != 0 && r.tclass == tmat_pkg::BG_CLASS) r.tclass = 8'd0;
    s = 4'($urandom_range(SLOTS - 1));
    case ($urandom_range(3))
      0: r.node = tun_in[s];
      1: r.node = tun_out[s];
      2: r.node = tun_from[s];
      default: r.node = tun_to[s];
    endcase
    case ($urandom_range(5))
      0: r.dst = tun_from[s];
      1: r.src = tun_to[s];
      2: r.dst = tun_to[s];
      3: r.src = tun_from[s];
      4: r.dst = r.node;
      default: r.src = r.node;
    endcase
    if ($urandom_range(3) == 0) r.src = pool_addr();
    return r;
  endfunction

  task automatic send_activate(logic [15:0] a, b, c, d);
    request_t r;
    r = rand_request();
    r.func = tmat_pkg::FN_ACTIVATE; r.a_in = a; r.a_out = b; r.a_from = c; r.a_to = d;
    send_request(r);
  endtask

  task automatic test_directed();
    request_t r;
    send_activate(16'h0010, 16'h0020, 16'h0030, 16'h0040);
    send_activate(16'h0000, 16'hffff, 16'h0000, 16'hffff);
    // one node holding several roles
    send_activate(16'h0050, 16'h0050, 16'h0050, 16'h0050);
    for (int k = 0; k < 16; k++) begin
      r = rand_request();
      r.func = tmat_pkg::FN_CLASSIFY;
      r.tclass = (k == 15) ? tmat_pkg::BG_CLASS : 8'hff;
      r.mig = k[1:0]; r.skip = k[2];
      case (k[3:2])
        0: begin r.node = 16'h0030; r.dst = 16'h0030; end
        1: begin r.node = 16'h0030; r.src = 16'h0030; end
        2: begin r.node = 16'h0040; r.dst = 16'h0040; end
        default: begin r.node = 16'h0010; r.dst = 16'h0030; end
      endcase
      send_request(r);
    end
    r = rand_request(); r.func = tmat_pkg::FN_UNUSED; send_request(r);
    r = rand_request(); r.func = tmat_pkg::FN_DEACTIVATE; r.uid = 16'd1; send_request(r);
    r = rand_request(); r.func = tmat_pkg::FN_DEACTIVATE; r.uid = 16'd1; send_request(r);
  endtask

  task automatic test_full_table();
    for (int k = 0; k < SLOTS + 2; k++)
      send_activate(pool_addr(), pool_addr(), pool_addr(), pool_addr());
    for (int k = 0; k < 40; k++) send_request(tunnel_packet());
  endtask

  task automatic test_uid_reuse();
    request_t r;
    // free the newest uid or a far one and take a slot under a fresh uid
    idle_pct = 0;
    for (int k = 0; k < 50; k++) begin
      r = rand_request(); r.func = tmat_pkg::FN_DEACTIVATE;
      r.uid = uid_counter - 16'd1;
      if (uid_counter[3:0] == 0) r.uid = 16'hffff - uid_counter;
      send_request(r);
      send_activate(pool_addr(), pool_addr(), pool_addr(), pool_addr());
    end
    idle_pct = 11;
  endtask

  task automatic test_random();
    request_t r;
    for (int k = 0; k < 1720; k++) begin
      if (k >= 600 && k < 900) idle_pct = 0; else idle_pct = 11;
      case ($urandom_range(9))
        0, 1: begin
          r = rand_request(); r.func = tmat_pkg::FN_ACTIVATE;
          r.a_in = pool_addr(); r.a_out = pool_addr();
          r.a_from = pool_addr(); r.a_to = pool_addr();
          if ($urandom_range(4) == 0) r.a_in = 16'($urandom);
        end
        2: begin
          r = rand_request(); r.func = tmat_pkg::FN_DEACTIVATE;
          if ($urandom_range(3) != 0) r.uid = uid_counter - 16'($urandom_range(20));
        end
        3: r = rand_request();
        default: r = tunnel_packet();
      endcase
      send_request(r);
    end
  endtask

  // result side: random stall and compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result action=%0d", $time, out_action);
        end else begin
          tmat_pkg::result_t e;
          e = expected_results.pop_front();
          if (e.action !== out_action || e.uid !== out_uid_out ||
              e.new_src !== out_new_src || e.new_dst !== out_new_dst ||
              e.push_addr !== out_push_addr || e.high_prio !== out_high_prio ||
              e.skip !== out_skip_flag_out || e.consumed !== out_consumed) begin
            errors++;
            $display("%0t mismatch exp act=%0d uid=%h src=%h dst=%h push=%h",
                     $time, e.action, e.uid, e.new_src, e.new_dst, e.push_addr,
                     " prio=%0d skip=%b cons=%b", e.high_prio, e.skip, e.consumed);
            $display("%0t          got act=%0d uid=%h src=%h dst=%h push=%h",
                     $time, out_action, out_uid_out, out_new_src, out_new_dst,
                     out_push_addr, " prio=%0d skip=%b cons=%b", out_high_prio,
                     out_skip_flag_out, out_consumed);
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT && !done) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0; in_func = '0; in_node_addr = '0; in_pkt_src = '0; in_pkt_dst = '0;
    in_traffic_class = '0; in_mig_state = '0; in_skip_flag_in = 0;
    in_in_addr = '0; in_out_addr = '0; in_from_addr = '0; in_to_addr = '0;
    in_tunnel_uid = '0; out_stall = 0;
    for (int s = 0; s < SLOTS; s++) begin
      tun_valid[s] = 0; tun_in[s] = '0; tun_out[s] = '0;
      tun_from[s] = '0; tun_to[s] = '0; tun_uid[s] = '0;
    end
    uid_counter = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random();
    test_uid_reuse();
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    done = 1;
    if (errors == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
